>>> rtl/htp_pkg.sv
// ============================================================================
// htp_pkg : shared types and constants for the two-anchor position finder
// Register indexes, field widths and sequencer states.
// ============================================================================
`timescale 1ns / 1ps

package htp_pkg;

   localparam int DIST_WIDTH_DEF = 16;

   localparam int ID_W    = 8;
   localparam int BASE_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IW  = 3;
   localparam int X_W     = 17;
   localparam int Y_W     = 16;

   localparam logic [CSR_IW-1:0] CSR_LEFT_ID   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ACROSS_ID = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_RIGHT_ID  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_BASE      = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_MAX_DIST  = 3'd4;

   localparam logic [ID_W-1:0]   LEFT_ID_RST   = 8'd0;
   localparam logic [ID_W-1:0]   ACROSS_ID_RST = 8'd1;
   localparam logic [ID_W-1:0]   RIGHT_ID_RST  = 8'd2;
   localparam logic [BASE_W-1:0] BASE_RST      = 16'd1000;
   localparam logic [BASE_W-1:0] MAX_DIST_RST  = 16'hFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL_P,
      ST_MUL_Q,
      ST_MUL_R,
      ST_SQRT_R,
      ST_DIV,
      ST_MUL_L,
      ST_MUL_Y,
      ST_DIFF,
      ST_SQRT_D,
      ST_FIN
   } state_type;

endpackage

>>> rtl/heron_triangulation_position.sv
// ============================================================================
// heron_triangulation_position : two-anchor position finder
// Stores per-anchor distances by node id and places the object by Heron's
// formula: height over the base and signed offset from the base midpoint.
// ============================================================================
// One word is processed at a time. Every product, both square roots and the
// division step through a single shared adder/subtractor, one bit (or one
// root digit) per cycle, and the multiplies stop early once the multiplier
// runs out of set bits. req_stall is high from acceptance until the result
// is loaded into the output register; a result waiting on rsp_stall does not
// block the next word from entering.
`timescale 1ns / 1ps

module heron_triangulation_position #(
   parameter int DIST_WIDTH = htp_pkg::DIST_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [htp_pkg::CSR_IW-1:0]        csr_index,
   input  logic [htp_pkg::CSR_W-1:0]         csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [htp_pkg::ID_W-1:0]          req_node_id,
   input  logic [DIST_WIDTH-1:0]             req_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [htp_pkg::X_W-1:0]    rsp_x_position,
   output logic [htp_pkg::Y_W-1:0]           rsp_y_position,
   output logic                              rsp_object_present,
   output logic                              rsp_node_matched
);

   import htp_pkg::*;

   localparam int W  = DIST_WIDTH;
   localparam int MW = (W > BASE_W) ? W : BASE_W;
   localparam int VW = MW + 1;
   localparam int FW = MW + 2;
   localparam int RW = 4 * FW;
   localparam int HW = 2 * FW;
   localparam int XW = MW + 3;
   localparam int CW = $clog2(RW / 2 + 1);

   localparam logic signed [XW-1:0] X_HI = XW'(65535);
   localparam logic signed [XW-1:0] X_LO = XW'(-65536);

   // configuration
   logic [ID_W-1:0]   left_id_ff, across_id_ff, right_id_ff;
   logic [BASE_W-1:0] base_ff, max_ff;

   // anchor distances
   logic [W-1:0] left_ff, across_ff, right_ff;
   logic [W-1:0] left_in, across_in, right_in;
   logic         matched_ff, matched_in;

   // sequencer and shared datapath
   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [RW-1:0]   acc_ff, acc_in;
   logic [RW-1:0]   mca_ff, mca_in;
   logic [RW-1:0]   mpl_ff, mpl_in;
   logic [HW-1:0]   hold_ff, hold_in;
   logic [W-1:0]    y_ff, y_in;

   // result word
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [X_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [Y_W-1:0]          rsp_y_ff, rsp_y_in;
   logic                    rsp_present_ff, rsp_present_in;
   logic                    rsp_matched_ff, rsp_matched_in;

   // shared adder
   logic [RW-1:0] alu_x, alu_y, alu_sum;
   logic          alu_sub, alu_co;

   // helpers
   logic            req_take, a_ge_b, degen, mpl_zero, root_bit;
   logic [VW-1:0]   t_v, d_v, c_v;
   logic [FW-1:0]   f_tmc, f_tpc, f_cmd, f_cpd;
   logic [W-1:0]    l_v, s_v;
   logic [RW-1:0]   rem_sh, trial, mul_acc;
   logic [MW-1:0]   y_ext;
   logic signed [XW-1:0] two_s, c_s, v_s, x_t, x_sat;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign a_ge_b = (left_ff >= right_ff);
   assign l_v    = a_ge_b ? left_ff : right_ff;
   assign t_v    = VW'(left_ff) + VW'(right_ff);
   assign d_v    = a_ge_b ? VW'(left_ff) - VW'(right_ff) : VW'(right_ff) - VW'(left_ff);
   assign c_v    = VW'(base_ff);
   assign degen  = (base_ff == '0) || (t_v < c_v) || (d_v > c_v);
   assign f_tmc  = FW'(t_v) - FW'(c_v);
   assign f_tpc  = FW'(t_v) + FW'(c_v);
   assign f_cmd  = FW'(c_v) - FW'(d_v);
   assign f_cpd  = FW'(c_v) + FW'(d_v);

   assign mpl_zero = (mpl_ff == '0);
   assign rem_sh   = {acc_ff[RW-3:0], mca_ff[RW-1:RW-2]};
   assign trial    = {mpl_ff[RW-3:0], 2'b01};
   assign root_bit = alu_co;

   always_comb begin
      unique case (state_ff)
         ST_SQRT_R, ST_SQRT_D: begin
            alu_x   = rem_sh;
            alu_y   = trial;
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_x   = acc_ff;
            alu_y   = mca_ff;
            alu_sub = 1'b1;
         end
         ST_DIFF: begin
            alu_x   = RW'(hold_ff);
            alu_y   = acc_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_x   = acc_ff;
            alu_y   = mca_ff;
            alu_sub = 1'b0;
         end
      endcase
   end

   assign {alu_co, alu_sum} = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                            + {{RW{1'b0}}, alu_sub};

   assign mul_acc = mpl_ff[0] ? alu_sum : acc_ff;

   // result formatting
   assign s_v   = mpl_ff[W-1:0];
   assign two_s = XW'({s_v, 1'b0});
   assign c_s   = XW'(base_ff);
   assign v_s   = a_ge_b ? two_s - c_s : c_s - two_s;
   assign x_t   = $signed(v_s + XW'(v_s[XW-1])) >>> 1;
   assign x_sat = (x_t > X_HI) ? X_HI : ((x_t < X_LO) ? X_LO : x_t);
   assign y_ext = MW'(y_ff);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      mca_in         = mca_ff;
      mpl_in         = mpl_ff;
      hold_in        = hold_ff;
      y_in           = y_ff;
      left_in        = left_ff;
      across_in      = across_ff;
      right_in       = right_ff;
      matched_in     = matched_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_present_in = rsp_present_ff;
      rsp_matched_in = rsp_matched_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               matched_in = 1'b0;
               if (req_node_id == left_id_ff) begin
                  left_in    = req_distance;
                  matched_in = 1'b1;
               end
               if (req_node_id == across_id_ff) begin
                  across_in  = req_distance;
                  matched_in = 1'b1;
               end
               if (req_node_id == right_id_ff) begin
                  right_in   = req_distance;
                  matched_in = 1'b1;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            acc_in = '0;
            if (degen) begin
               y_in     = '0;
               mca_in   = RW'(l_v);
               mpl_in   = RW'(l_v);
               state_in = ST_MUL_L;
            end else begin
               mca_in   = RW'(f_tmc);
               mpl_in   = RW'(f_tpc);
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            if (mpl_zero) begin
               hold_in  = acc_ff[HW-1:0];
               acc_in   = '0;
               mca_in   = RW'(f_cmd);
               mpl_in   = RW'(f_cpd);
               state_in = ST_MUL_Q;
            end else begin
               acc_in = mul_acc;
               mca_in = mca_ff << 1;
               mpl_in = mpl_ff >> 1;
            end
         end
         ST_MUL_Q: begin
            if (mpl_zero) begin
               acc_in   = '0;
               mca_in   = RW'(hold_ff);
               mpl_in   = acc_ff;
               state_in = ST_MUL_R;
            end else begin
               acc_in = mul_acc;
               mca_in = mca_ff << 1;
               mpl_in = mpl_ff >> 1;
            end
         end
         ST_MUL_R: begin
            if (mpl_zero) begin
               acc_in   = '0;
               mca_in   = acc_ff;
               mpl_in   = '0;
               cnt_in   = CW'(RW / 2);
               state_in = ST_SQRT_R;
            end else begin
               acc_in = mul_acc;
               mca_in = mca_ff << 1;
               mpl_in = mpl_ff >> 1;
            end
         end
         ST_SQRT_R, ST_SQRT_D: begin
            if (cnt_ff == '0) begin
               if (state_ff == ST_SQRT_R) begin
                  // height = root / (2c), quotient known to fit W bits
                  acc_in   = mpl_ff;
                  mca_in   = RW'(base_ff) << W;
                  mpl_in   = '0;
                  cnt_in   = CW'(W);
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_FIN;
               end
            end else begin
               acc_in = root_bit ? alu_sum : rem_sh;
               mpl_in = {mpl_ff[RW-2:0], root_bit};
               mca_in = mca_ff << 2;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               y_in     = mpl_ff[W-1:0];
               acc_in   = '0;
               mca_in   = RW'(l_v);
               mpl_in   = RW'(l_v);
               state_in = ST_MUL_L;
            end else begin
               if (alu_co) begin
                  acc_in = alu_sum;
               end
               mpl_in = {mpl_ff[RW-2:0], alu_co};
               mca_in = mca_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL_L: begin
            if (mpl_zero) begin
               hold_in  = acc_ff[HW-1:0];
               acc_in   = '0;
               mca_in   = RW'(y_ff);
               mpl_in   = RW'(y_ff);
               state_in = ST_MUL_Y;
            end else begin
               acc_in = mul_acc;
               mca_in = mca_ff << 1;
               mpl_in = mpl_ff >> 1;
            end
         end
         ST_MUL_Y: begin
            if (mpl_zero) begin
               state_in = ST_DIFF;
            end else begin
               acc_in = mul_acc;
               mca_in = mca_ff << 1;
               mpl_in = mpl_ff >> 1;
            end
         end
         ST_DIFF: begin
            // l^2 - y^2, left-aligned for the root
            mca_in   = alu_sum << (RW - 2 * W);
            acc_in   = '0;
            mpl_in   = '0;
            cnt_in   = CW'(W);
            state_in = ST_SQRT_D;
         end
         ST_FIN: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = x_sat[X_W-1:0];
               rsp_y_in       = (y_ext > MW'(16'hFFFF)) ? '1 : y_ext[Y_W-1:0];
               rsp_present_in = (MW'(left_ff) <= MW'(max_ff))
                             && (MW'(across_ff) <= MW'(max_ff))
                             && (MW'(right_ff) <= MW'(max_ff));
               rsp_matched_in = matched_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_id_ff   <= LEFT_ID_RST;
         across_id_ff <= ACROSS_ID_RST;
         right_id_ff  <= RIGHT_ID_RST;
         base_ff      <= BASE_RST;
         max_ff       <= MAX_DIST_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT_ID:   left_id_ff   <= csr_data[ID_W-1:0];
            CSR_ACROSS_ID: across_id_ff <= csr_data[ID_W-1:0];
            CSR_RIGHT_ID:  right_id_ff  <= csr_data[ID_W-1:0];
            CSR_BASE:      base_ff      <= csr_data[BASE_W-1:0];
            CSR_MAX_DIST:  max_ff       <= csr_data[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         across_ff    <= '0;
         right_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         across_ff    <= across_in;
         right_ff     <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      acc_ff         <= acc_in;
      mca_ff         <= mca_in;
      mpl_ff         <= mpl_in;
      hold_ff        <= hold_in;
      y_ff           <= y_in;
      matched_ff     <= matched_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_present_ff <= rsp_present_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_x_position     = rsp_x_ff;
   assign rsp_y_position     = rsp_y_ff;
   assign rsp_object_present = rsp_present_ff;
   assign rsp_node_matched   = rsp_matched_ff;

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_SETUP)
      else $error("accepted word did not start the sequencer");

   a_rsp_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result raised outside the final step");

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT_R || state_ff == ST_SQRT_D || state_ff == ST_DIV)
      |-> cnt_ff <= CW'(RW / 2))
      else $error("step counter out of range");

   a_height_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL_L |-> (y_ff <= left_ff) && (y_ff <= right_ff))
      else $error("height exceeds an anchor distance");

endmodule
